// ===== sv/circle_outline_point_generator_unit_assert.svh =====
// Assertion macros shared by the checker of the circle outline point generator.
`ifndef CIRCLE_OUTLINE_POINT_GENERATOR_UNIT_ASSERT_SVH
`define CIRCLE_OUTLINE_POINT_GENERATOR_UNIT_ASSERT_SVH

// Check a property on the rising clock, ignored while reset is asserted.
`define COOPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a signal holds across the edge that follows a condition.
`define COOPG_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== sv/coopg_pkg.sv =====
// Shared widths, register indexes and types of the circle outline point generator.
package coopg_pkg;

  localparam int GridSize  = 1024;
  localparam int CoordW    = 10;
  localparam int OffW      = 11;
  localparam int TermW     = 14;
  localparam int PixW      = 12;
  localparam int PtW       = 14;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 10;
  localparam int NumPoints = 8;
  localparam int PtIdxW    = 3;

  localparam int YStepInit = -2;
  localparam int TermDec   = 4;

  localparam logic [CoordW-1:0] CenterXReset = 10'd32;
  localparam logic [CoordW-1:0] CenterYReset = 10'd32;
  localparam logic [CoordW-1:0] RadiusReset  = 10'd20;

  typedef enum logic [CfgIdxW-1:0] {
    RegCenterX = 2'd0,
    RegCenterY = 2'd1,
    RegRadius  = 2'd2
  } cfg_reg_e;

  // One step as handed from the state update to the point emitter.
  typedef struct packed {
    logic                   emit;
    logic signed [OffW-1:0] x;
    logic signed [OffW-1:0] y;
    logic                   done;
  } step_t;

endpackage

// ===== sv/coopg_if.sv =====
// Handshake channels of the circle outline point generator: config, step item, point.
interface coopg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [coopg_pkg::CfgIdxW-1:0]    index;
  logic [coopg_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface coopg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface coopg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [coopg_pkg::PixW-1:0]   pixel_x;
  logic signed [coopg_pkg::PixW-1:0]   pixel_y;
  logic                                on_grid;
  logic                                last_of_step;
  logic                                circle_done;

  modport source (output valid, output pixel_x, output pixel_y, output on_grid,
                  output last_of_step, output circle_done, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input on_grid,
                  input last_of_step, input circle_done, output ready);
endinterface

// ===== sv/coopg_step.sv =====
// Circle state registers and the midpoint update for one step item.
module coopg_step (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [coopg_pkg::CoordW-1:0]     radius_i,
  input  logic                             advance_i,
  input  logic                             restart_i,
  output coopg_pkg::step_t                 step_o
);

  localparam int OffW  = coopg_pkg::OffW;
  localparam int TermW = coopg_pkg::TermW;

  logic signed [OffW-1:0]  x_q, y_q, x_d, y_d;
  logic signed [TermW-1:0] dec_q, xt_q, yt_q, dec_d, xt_d, yt_d;
  logic                    active_q, active_d;

  logic signed [OffW-1:0]  x0, y0, x1, y1;
  logic signed [TermW-1:0] dec0, xt0, yt0, dec1, dec2, xt1, yt1;
  logic                    act0, done;

  always_comb begin
    // Load the start state on restart, else carry the circle in progress.
    if (restart_i) begin
      x0   = OffW'({1'b0, radius_i});
      y0   = '0;
      dec0 = TermW'({radius_i, 1'b0}) - TermW'(1);
      xt0  = TermW'({radius_i, 2'b00}) - TermW'(coopg_pkg::TermDec);
      yt0  = TermW'(coopg_pkg::YStepInit);
      act0 = 1'b1;
    end else begin
      x0   = x_q;
      y0   = y_q;
      dec0 = dec_q;
      xt0  = xt_q;
      yt0  = yt_q;
      act0 = active_q;
    end

    dec1 = dec0 + yt0;
    yt1  = yt0 - TermW'(coopg_pkg::TermDec);
    y1   = y0 + OffW'(1);
    if (dec1[TermW-1]) begin
      dec2 = dec1 + xt0;
      xt1  = xt0 - TermW'(coopg_pkg::TermDec);
      x1   = x0 - OffW'(1);
    end else begin
      dec2 = dec1;
      xt1  = xt0;
      x1   = x0;
    end
    done = y1 > x1;

    step_o.emit = act0;
    step_o.x    = x0;
    step_o.y    = y0;
    step_o.done = done;

    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    xt_d     = xt_q;
    yt_d     = yt_q;
    active_d = active_q;
    if (advance_i && act0) begin
      x_d      = x1;
      y_d      = y1;
      dec_d    = dec2;
      xt_d     = xt1;
      yt_d     = yt1;
      active_d = !done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      xt_q     <= '0;
      yt_q     <= '0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      xt_q     <= xt_d;
      yt_q     <= yt_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== sv/circle_outline_point_generator_unit.sv =====
// Circle outline generator: eight-way midpoint circle, one point per cycle while not stalled.
//
// Each accepted step item (restart set, or a circle in progress) yields eight outline
// points, one per cycle on the output channel while it is not stalled; the sustained
// step rate is set by the single point channel and the three-bit point counter that
// walks the eight symmetric points of a step. The first point of a step passes through
// the step register and then the output register. The next step item is accepted in
// the cycle the eighth point of the current step moves into the output register, so a
// stalled eighth point never blocks the state update of the following step. A restart
// item loads the start state from the radius register and gives the first step at once;
// a restart during a circle abandons it. A step item with restart clear and no circle in
// progress is taken and gives nothing. Points use the live centre registers; a new
// radius counts from the next restart. Points off the grid come out with on_grid clear.
// The configuration port is always ready; writes beyond the third register are dropped.
module circle_outline_point_generator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  coopg_cfg_if.sink     cfg_i,
  coopg_in_if.sink      in_i,
  coopg_out_if.source   out_o
);

  localparam int CW     = coopg_pkg::CoordW;
  localparam int OffW   = coopg_pkg::OffW;
  localparam int PtW    = coopg_pkg::PtW;
  localparam int PixW   = coopg_pkg::PixW;
  localparam int PtIdxW = coopg_pkg::PtIdxW;

  // Configuration registers
  logic [CW-1:0] cx_q, cy_q, rad_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= coopg_pkg::CenterXReset;
      cy_q  <= coopg_pkg::CenterYReset;
      rad_q <= coopg_pkg::RadiusReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        coopg_pkg::RegCenterX: cx_q  <= cfg_i.data[CW-1:0];
        coopg_pkg::RegCenterY: cy_q  <= cfg_i.data[CW-1:0];
        coopg_pkg::RegRadius:  rad_q <= cfg_i.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the step register and the output register
  logic              stp_valid_q;
  logic [PtIdxW-1:0] k_q;
  logic              out_valid_q;
  logic              out_free, emit_fire, last_pt, in_acc;

  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_fire = stp_valid_q && out_free;
  assign last_pt   = (k_q == PtIdxW'(coopg_pkg::NumPoints - 1));
  assign in_i.ready = !stp_valid_q || (emit_fire && last_pt);
  assign in_acc    = in_i.valid && in_i.ready;

  // State update for the item at the input
  coopg_pkg::step_t step;

  coopg_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .radius_i  (rad_q),
    .advance_i (in_acc),
    .restart_i (in_i.restart),
    .step_o    (step)
  );

  // Step register: offsets and done flag of the step being emitted
  logic signed [OffW-1:0] sx_q, sy_q;
  logic                   sdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stp_valid_q <= 1'b0;
      k_q         <= '0;
    end else if (in_acc && step.emit) begin
      stp_valid_q <= 1'b1;
      k_q         <= '0;
    end else if (emit_fire) begin
      k_q <= k_q + PtIdxW'(1);
      if (last_pt) begin
        stp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && step.emit) begin
      sx_q    <= step.x;
      sy_q    <= step.y;
      sdone_q <= step.done;
    end
  end

  // Point selection: bit 2 swaps the offsets, bit 0 and bit 1 pick the signs.
  logic signed [OffW-1:0] off_a, off_b;
  logic signed [PtW-1:0]  ext_a, ext_b, px, py;
  logic                   px_in, py_in;

  always_comb begin
    off_a = k_q[2] ? sy_q : sx_q;
    off_b = k_q[2] ? sx_q : sy_q;
    ext_a = {{(PtW-OffW){off_a[OffW-1]}}, off_a};
    ext_b = {{(PtW-OffW){off_b[OffW-1]}}, off_b};
    px = k_q[0] ? ($signed({{(PtW-CW){1'b0}}, cx_q}) + ext_a)
                : ($signed({{(PtW-CW){1'b0}}, cx_q}) - ext_a);
    py = k_q[1] ? ($signed({{(PtW-CW){1'b0}}, cy_q}) + ext_b)
                : ($signed({{(PtW-CW){1'b0}}, cy_q}) - ext_b);
    px_in = !px[PtW-1] && (px[PtW-2:0] < (PtW-1)'(coopg_pkg::GridSize));
    py_in = !py[PtW-1] && (py[PtW-2:0] < (PtW-1)'(coopg_pkg::GridSize));
  end

  // Output register
  logic signed [PixW-1:0] pix_x_q, pix_y_q;
  logic                   on_grid_q, last_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      pix_x_q   <= px[PixW-1:0];
      pix_y_q   <= py[PixW-1:0];
      on_grid_q <= px_in && py_in;
      last_q    <= last_pt;
      done_q    <= last_pt && sdone_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_x      = pix_x_q;
  assign out_o.pixel_y      = pix_y_q;
  assign out_o.on_grid      = on_grid_q;
  assign out_o.last_of_step = last_q;
  assign out_o.circle_done  = done_q;

endmodule

// ===== sv/coopg_checker.sv =====
// Port-level checks of the circle outline point generator and their bind.
`include "circle_outline_point_generator_unit_assert.svh"

module coopg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [coopg_pkg::PixW-1:0] pixel_x_i,
  input logic signed [coopg_pkg::PixW-1:0] pixel_y_i,
  input logic                              on_grid_i,
  input logic                              last_of_step_i,
  input logic                              circle_done_i
);

  // A circle only ends on the eighth point of a step.
  `COOPG_ASSERT(a_done_on_last, out_valid_i && circle_done_i |-> last_of_step_i, "circle_done off the eighth point")

  // A point on the grid never has a negative coordinate.
  `COOPG_ASSERT(a_grid_sign, out_valid_i && on_grid_i |-> !pixel_x_i[coopg_pkg::PixW-1] && !pixel_y_i[coopg_pkg::PixW-1], "on_grid with a negative coordinate")

  // A stalled point stays valid and keeps its pixel_x.
  `COOPG_ASSERT(a_valid_holds, out_valid_i && !out_ready_i |=> out_valid_i, "point dropped while stalled")
  `COOPG_ASSERT_HOLD(a_x_holds, out_valid_i && !out_ready_i, pixel_x_i, "pixel_x changed while stalled")

endmodule

bind circle_outline_point_generator_unit coopg_checker u_coopg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .pixel_x_i      (out_o.pixel_x),
  .pixel_y_i      (out_o.pixel_y),
  .on_grid_i      (out_o.on_grid),
  .last_of_step_i (out_o.last_of_step),
  .circle_done_i  (out_o.circle_done)
);

// ===== tb/circle_outline_point_checker.sv =====
// Checker for the circle outline generator: tracks the circle state and checks every point item.
module circle_outline_point_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  coopg_cfg_if  cfg_i,
  coopg_in_if   in_i,
  coopg_out_if  out_i,
  output int    mismatches_o,
  output int    pending_o,
  output int    traced_steps_o,
  output int    points_o,
  output int    circles_o,
  output int    off_grid_o
);

  localparam int PixW      = coopg_pkg::PixW;
  localparam int CoordW    = coopg_pkg::CoordW;
  localparam int OffW      = coopg_pkg::OffW;
  localparam int TermW     = coopg_pkg::TermW;
  localparam int NumPoints = coopg_pkg::NumPoints;
  localparam int GridSize  = coopg_pkg::GridSize;

  typedef struct packed {
    logic signed [PixW-1:0] pixel_x;
    logic signed [PixW-1:0] pixel_y;
    logic                   on_grid;
    logic                   last_of_step;
    logic                   circle_done;
  } outline_point_t;

  outline_point_t outline_q[$];

  // Shadow registers and walker state.
  logic [CoordW-1:0]       ctr_x, ctr_y, rad;
  logic signed [OffW-1:0]  x_off, y_off;
  logic signed [TermW-1:0] err_acc, x_term, y_term;
  logic                    tracing;

  function automatic outline_point_t make_point(int px, int py, logic last, logic fin);
    outline_point_t p;
    p.pixel_x      = px[PixW-1:0];
    p.pixel_y      = py[PixW-1:0];
    p.on_grid      = (px >= 0 && px < GridSize && py >= 0 && py < GridSize);
    p.last_of_step = last;
    p.circle_done  = last && fin;
    return p;
  endfunction

  // Advance the walker by one step, if a circle is open, and queue its eight mirrored points.
  task automatic trace_step(input logic restart);
    int   r, cx, cy, x0, y0;
    int   dx[NumPoints];
    int   dy[NumPoints];
    logic fin;
    r = int'(rad);
    if (restart) begin
      x_off   = {1'b0, rad};
      y_off   = '0;
      err_acc = TermW'(2 * r - 1);
      x_term  = TermW'(4 * r - 4);
      y_term  = TermW'(coopg_pkg::YStepInit);
      tracing = 1'b1;
    end
    if (!tracing) return;
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    x0 = int'(x_off);
    y0 = int'(y_off);
    err_acc = err_acc + y_term;
    y_term  = y_term - TermW'(coopg_pkg::TermDec);
    y_off   = y_off + OffW'(1);
    if (err_acc < 0) begin
      err_acc = err_acc + x_term;
      x_term  = x_term - TermW'(coopg_pkg::TermDec);
      x_off   = x_off - OffW'(1);
    end
    fin = (y_off > x_off);
    if (fin) tracing = 1'b0;
    dx = '{-x0, x0, -x0, x0, -y0, y0, -y0, y0};
    dy = '{-y0, -y0, y0, y0, -x0, -x0, x0, x0};
    for (int k = 0; k < NumPoints; k++) begin
      outline_q.push_back(make_point(cx + dx[k], cy + dy[k], k == NumPoints - 1, fin));
    end
    traced_steps_o++;
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  task automatic check_point();
    outline_point_t want;
    if (outline_q.size() == 0) begin
      mismatches_o++;
      $display("%0t: unexpected point, expected none, got x=%0d y=%0d", $time,
               int'(out_i.pixel_x), int'(out_i.pixel_y));
      return;
    end
    want = outline_q.pop_front();
    check_field("pixel_x", int'($signed(want.pixel_x)), int'(out_i.pixel_x));
    check_field("pixel_y", int'($signed(want.pixel_y)), int'(out_i.pixel_y));
    check_field("on_grid", int'(want.on_grid), int'(out_i.on_grid));
    check_field("last_of_step", int'(want.last_of_step), int'(out_i.last_of_step));
    check_field("circle_done", int'(want.circle_done), int'(out_i.circle_done));
    if (!want.on_grid) off_grid_o++;
    if (out_i.circle_done) circles_o++;
    points_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outline_q.delete();
      ctr_x          = coopg_pkg::CenterXReset;
      ctr_y          = coopg_pkg::CenterYReset;
      rad            = coopg_pkg::RadiusReset;
      x_off          = '0;
      y_off          = '0;
      err_acc        = '0;
      x_term         = '0;
      y_term         = '0;
      tracing        = 1'b0;
      mismatches_o   = 0;
      pending_o      = 0;
      traced_steps_o = 0;
      points_o       = 0;
      circles_o      = 0;
      off_grid_o     = 0;
    end else begin
      if (out_i.valid && out_i.ready) check_point();
      if (in_i.valid && in_i.ready) trace_step(in_i.restart);
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          coopg_pkg::RegCenterX: ctr_x = cfg_i.data;
          coopg_pkg::RegCenterY: ctr_y = cfg_i.data;
          coopg_pkg::RegRadius:  rad   = cfg_i.data;
          default:    ;
        endcase
      end
      pending_o = outline_q.size();
    end
  end

endmodule

// ===== tb/circle_outline_point_generator_unit_test.sv =====
// Top of the circle outline generator regression: clock, reset, stimulus and verdict.
module circle_outline_point_generator_unit_test;

  localparam int ClkHalf      = 10;
  localparam int ResetCycles  = 7;
  // Cycles to let pass once the last point has arrived, so that an item that
  // gives nothing has surely been taken in before a register is touched.
  localparam int SettleCycles = 12;
  localparam int RandomItems  = 380;
  localparam int LongStall    = 120;
  localparam int LimitCycles  = 500000;
  localparam int CfgIdxW      = coopg_pkg::CfgIdxW;
  localparam int CfgDataW     = coopg_pkg::CfgDataW;
  // Index past the last register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  coopg_cfg_if cfg_ch ();
  coopg_in_if  step_ch ();
  coopg_out_if pt_ch ();

  int mismatches, pending, traced_steps, points, circles, off_grid;

  // Idle mix, in percent of cycles.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  // Each increment asks the point sink for one long hold-off.
  int stall_asks    = 0;
  // Radius last written, used to size the step runs.
  int rad_now       = int'(coopg_pkg::RadiusReset);

  circle_outline_point_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (step_ch),
    .out_o  (pt_ch)
  );

  circle_outline_point_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_ch),
    .in_i           (step_ch),
    .out_i          (pt_ch),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .traced_steps_o (traced_steps),
    .points_o       (points),
    .circles_o      (circles),
    .off_grid_o     (off_grid)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Point sink: random back-pressure, plus a long hold-off on request, counted here.
  initial begin : point_sink
    int hold_left;
    int asks_taken;
    pt_ch.ready = 1'b0;
    hold_left   = 0;
    asks_taken  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_asks != asks_taken) begin
        asks_taken = stall_asks;
        hold_left  = LongStall;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt_ch.ready <= 1'b0;
      end else begin
        pt_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Steps a circle of radius r needs before y passes x, give or take one.
  function automatic int steps_to_close(int r);
    return r * 707 / 1000 + 1;
  endfunction

  // Centre coordinate: mostly anywhere, sometimes hugging an edge so points fall off.
  function automatic logic [CfgDataW-1:0] pick_centre();
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(1) == 0) return CfgDataW'($urandom_range(15));
      return CfgDataW'(1008 + $urandom_range(15));
    end
    return CfgDataW'($urandom_range(1023));
  endfunction

  // Offer one step item; idle first at the sender's rate, then hold until taken.
  task automatic offer_step(input logic restart);
    while ($urandom_range(99) < src_idle_pct) begin
      step_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    step_ch.valid   <= 1'b1;
    step_ch.restart <= restart;
    @(posedge clk_i);
    while (!step_ch.ready) @(posedge clk_i);
  endtask

  // Restart, then advance n times.
  task automatic run_circle(input int n);
    offer_step(1'b1);
    for (int k = 0; k < n; k++) offer_step(1'b0);
  endtask

  // Drop valid and wait until every expected point has come out, then settle.
  task automatic drain_points();
    step_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write centre and radius back to back; optionally poke the unused index too.
  task automatic write_regs(input logic [CfgDataW-1:0] cx, input logic [CfgDataW-1:0] cy,
                            input logic [CfgDataW-1:0] r, input bit poke_spare);
    logic [CfgIdxW-1:0]  idx[4];
    logic [CfgDataW-1:0] val[4];
    int                  n;
    idx = '{coopg_pkg::RegCenterX, coopg_pkg::RegCenterY, coopg_pkg::RegRadius, RegSpare};
    val = '{cx, cy, r, CfgDataW'($urandom_range(1023))};
    n   = poke_spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
    end
    cfg_ch.valid <= 1'b0;
    rad_now = int'(r);
  endtask

  initial begin : stimulus
    int base;
    int pick;
    int n;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = coopg_pkg::RegCenterX;
    cfg_ch.data     = '0;
    step_ch.valid   = 1'b0;
    step_ch.restart = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, registers at their reset values first.
    // A plain step with no circle in progress must give nothing.
    offer_step(1'b0);
    // Start a circle, advance once, then restart it in mid-flight and advance once more.
    offer_step(1'b1);
    offer_step(1'b0);
    offer_step(1'b1);
    offer_step(1'b0);
    drain_points();

    // Zero radius in the corner: one step at the centre, flagged done, all eight points on the grid.
    // Also write the unused index, which must change nothing.
    write_regs(10'd0, 10'd0, 10'd0, 1'b1);
    offer_step(1'b1);
    offer_step(1'b0);
    drain_points();

    // Largest centre and radius: coordinates reach 0 and 2046, far past the top of the grid.
    write_regs(10'd1023, 10'd1023, 10'd1023, 1'b0);
    run_circle(3);
    drain_points();

    // Unit radius on an edge, run past its end; the open circle above is abandoned.
    write_regs(10'd0, 10'd1023, 10'd1, 1'b0);
    run_circle(2);
    drain_points();

    // A small full circle well inside the grid.
    write_regs(10'd5, 10'd700, 10'd3, 1'b0);
    run_circle(steps_to_close(3));
    drain_points();

    // Random part in three idle mixes.
    base = traced_steps;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 9;
          sink_idle_pct <= 79;
        end
        1: begin
          src_idle_pct  = 79;
          sink_idle_pct <= 9;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
          // Hold the sink off for a long stretch while steps keep coming, so the
          // block fills and stalls its input, then pause until all points are out.
          drain_points();
          write_regs(10'd512, 10'd512, 10'd40, 1'b0);
          stall_asks <= stall_asks + 1;
          run_circle(steps_to_close(40));
          drain_points();
        end
      endcase
      while (traced_steps - base < RandomItems * (ph + 1) / 3) begin
        // New settings now and then, only once the block is quiet.
        if ($urandom_range(3) == 0) begin
          drain_points();
          write_regs(pick_centre(), pick_centre(),
                     CfgDataW'(($urandom_range(7) == 0) ? $urandom_range(25, 90)
                                                        : $urandom_range(24)),
                     $urandom_range(9) == 0);
        end
        pick = $urandom_range(99);
        n    = steps_to_close(rad_now) + $urandom_range(1);
        if (pick < 10) begin
          // Stray advance: ignored unless a circle is still open.
          offer_step(1'b0);
        end else if (pick < 25) begin
          // Broken run: cut short, the next restart abandons it.
          run_circle($urandom_range(n));
        end else begin
          run_circle(n);
        end
      end
    end

    drain_points();
    $display("Covered %0d step items giving %0d points, %0d circles closed, %0d off the grid,",
             traced_steps, points, circles, off_grid);
    $display("over three idle mixes with one long sink hold-off and register extremes.");
    if (mismatches == 0 && pending == 0) begin
      $display("circle_outline_point_generator_unit regression: pass");
    end else begin
      $display("circle_outline_point_generator_unit regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #(2 * ClkHalf * LimitCycles);
    $display("Timed out with %0d points still expected", pending);
    $display("circle_outline_point_generator_unit regression: fail");
    $finish;
  end

endmodule
